/* rtl/sis_pkg.sv */
// shared types and defaults for the stack insertion sorter
package sis_pkg;

    localparam int DEFAULT_DEPTH       = 16;
    localparam int DEFAULT_VALUE_WIDTH = 16;
    localparam int FIELD_W             = 16;

    typedef struct packed {
        logic ins;
        logic shift;
    } sis_ctrl_t;

endpackage

/* rtl/sis_cell.sv */
// one slot of the sorted chain: holds a value, inserts in order, shifts toward the head
module sis_cell #(
    parameter int W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  sis_pkg::sis_ctrl_t ctrl,
    input  logic [W-1:0]     new_val,
    input  logic             prev_valid,
    input  logic [W-1:0]     prev_data,
    input  logic             prev_less,
    input  logic             next_valid,
    input  logic [W-1:0]     next_data,
    output logic             valid,
    output logic [W-1:0]     data,
    output logic             less
);
    import sis_pkg::*;

    logic         valid_reg, valid_next;
    logic [W-1:0] data_reg, data_next;

    // stored value sorts strictly before the arriving one
    assign less  = valid_reg && (data_reg < new_val);
    assign valid = valid_reg;
    assign data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.ins) begin
            if (!less) begin
                if (prev_less) begin
                    valid_next = 1'b1;
                    data_next  = new_val;
                end else begin
                    valid_next = prev_valid;
                    data_next  = prev_data;
                end
            end
        end else if (ctrl.shift) begin
            valid_next = next_valid;
            data_next  = next_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

/* rtl/stack_insertion_sorter_core.sv */
// top level of the stack insertion sorter: chain of sorting cells plus run control
//
// usage
// - input words arrive on s_axis (s_tdata = value, s_tlast = last value of a set)
// - each accepted value is inserted into a chain of DEPTH cells kept in
//   ascending order; all cells compare against the value at once
// - while the chain is full further values are dropped and the overflow flag is set
// - the word with s_tlast is inserted as well, then the block drains the chain on
//   m_axis: smallest value first, m_tlast on the largest, m_tuser = overflow
// - throughput: one input word per cycle while filling; during the drain the
//   input is held off (s_tready low) and one result word leaves per cycle
//   while m_tready is high; each taken word shifts the chain one cell toward the head
// - latency: first result is offered the cycle after the last input word is taken
// - a stalled receiver (m_tready low) simply freezes the chain; nothing is lost
// - after the final word is taken the flag clears and s_tready returns next cycle
// - reset (aresetn low, synchronous) empties the chain and clears the flag;
//   no clearing pass is needed since emptiness lives in per-cell valid bits
module stack_insertion_sorter_core #(
    parameter int DEPTH       = sis_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = sis_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sis_pkg::FIELD_W-1:0] s_tdata,  // [15:0] value
    input  logic                        s_tlast,  // last_in
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sis_pkg::FIELD_W-1:0] m_tdata,  // [15:0] sorted_value
    output logic                        m_tlast,  // last_out
    output logic                        m_tuser   // overflow
);
    import sis_pkg::*;

    // only the low VALUE_WIDTH bits of a value are kept
    localparam int W = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    state_t      state_reg;
    logic        dropped_reg;

    sis_ctrl_t   ctrl;
    logic        s_acc, m_acc, full;
    logic [W-1:0] new_val;

    logic [W-1:0] data_w  [DEPTH];
    logic [DEPTH-1:0] valid_w;
    logic [DEPTH-1:0] less_w;

    assign new_val = s_tdata[W-1:0];
    assign full    = valid_w[DEPTH-1];

    assign s_tready = (state_reg == ST_FILL);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    // a value is inserted only if a free cell remains
    assign ctrl.ins   = s_acc && !full;
    assign ctrl.shift = (state_reg == ST_DRAIN) && m_tready;

    // head cell feeds the output
    assign m_tvalid = (state_reg == ST_DRAIN) && valid_w[0];
    assign m_tdata  = FIELD_W'(data_w[0]);
    assign m_tlast  = !valid_w[1];
    assign m_tuser  = dropped_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic         pv, pl, nv;
        logic [W-1:0] pd, nd;

        if (i == 0) begin : g_head
            // head boundary: everything before it sorts lower
            assign pv = 1'b0;
            assign pd = '0;
            assign pl = 1'b1;
        end else begin : g_body
            assign pv = valid_w[i-1];
            assign pd = data_w[i-1];
            assign pl = less_w[i-1];
        end

        if (i == DEPTH-1) begin : g_tail
            assign nv = 1'b0;
            assign nd = '0;
        end else begin : g_mid
            assign nv = valid_w[i+1];
            assign nd = data_w[i+1];
        end

        sis_cell #(.W(W)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_val    (new_val),
            .prev_valid (pv),
            .prev_data  (pd),
            .prev_less  (pl),
            .next_valid (nv),
            .next_data  (nd),
            .valid      (valid_w[i]),
            .data       (data_w[i]),
            .less       (less_w[i])
        );
    end

    // run control: fill until a last word, then drain to empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_FILL;
            dropped_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_FILL: begin
                    if (s_acc) begin
                        if (full) begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (m_acc && m_tlast) begin
                        state_reg   <= ST_FILL;
                        dropped_reg <= 1'b0;
                    end
                end
                default: state_reg <= ST_FILL;
            endcase
        end
    end

    // occupied cells always form a contiguous run from the head
    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (((valid_w >> 1) & ~valid_w) == '0))
        else $error("hole in the sorted chain");

    // a drain never has an empty head
    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> valid_w[0])
        else $error("drain with empty chain");

    // overflow only rises when a word met a full chain
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(dropped_reg) |-> $past(full && s_acc))
        else $error("overflow without full chain");

    // the final word leaves the chain empty and reopens the input
    a_end_of_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_tlast) |=> (s_tready && !valid_w[0] && !dropped_reg))
        else $error("chain not empty after final word");

endmodule

/* dv/sorted_run_checker.sv */
// checker for the insertion sorter: predicts each sorted run and compares result words
module sorted_run_checker #(
    parameter int DEPTH       = sis_pkg::DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = sis_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [sis_pkg::FIELD_W-1:0] s_tdata,
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [sis_pkg::FIELD_W-1:0] m_tdata,
    input  logic                        m_tlast,
    input  logic                        m_tuser,
    output int                          errors,
    output int                          pending,
    output int                          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = sis_pkg::FIELD_W;
    localparam logic [W-1:0] VALUE_MASK =
        (VALUE_WIDTH >= W) ? {W{1'b1}} : W'((64'd1 << VALUE_WIDTH) - 64'd1);

    typedef struct packed {
        logic [W-1:0] value;
        logic         last;
        logic         overflow;
    } sorted_word_t;

    logic [W-1:0]  run_store [DEPTH];
    int            run_fill;
    logic          run_dropped;
    sorted_word_t  sorted_words [$];

    // place a value in front of every stored value that is not smaller
    function automatic void insert_value(logic [W-1:0] v);
        int pos;
        pos = 0;
        if (run_fill >= DEPTH) begin
            run_dropped = 1'b1;
            return;
        end
        while (pos < run_fill && run_store[pos] < v) pos++;
        for (int i = run_fill; i > pos; i--) run_store[i] = run_store[i-1];
        run_store[pos] = v;
        run_fill++;
    endfunction

    // end of run: every stored value leaves smallest first, then the store empties
    function automatic void close_run();
        sorted_word_t w;
        for (int k = 0; k < run_fill; k++) begin
            w.value    = run_store[k];
            w.last     = (k == run_fill - 1);
            w.overflow = run_dropped;
            sorted_words.push_back(w);
        end
        run_fill    = 0;
        run_dropped = 1'b0;
    endfunction

    initial begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    always @(posedge aclk) begin
        sorted_word_t want;
        if (!aresetn) begin
            run_fill    = 0;
            run_dropped = 1'b0;
            sorted_words.delete();
            pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (sorted_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got value %h last %b ovf %b",
                             $time, m_tdata, m_tlast, m_tuser);
                    errors <= errors + 1;
                end else begin
                    want = sorted_words.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.last ||
                        m_tuser !== want.overflow) begin
                        $display("%0t: mismatch: exp %h last %b ovf %b, got %h last %b ovf %b",
                                 $time, want.value, want.last, want.overflow,
                                 m_tdata, m_tlast, m_tuser);
                        errors <= errors + 1;
                    end
                end
                checked <= checked + 1;
            end
            if (s_tvalid && s_tready) begin
                insert_value(s_tdata & VALUE_MASK);
                if (s_tlast) close_run();
            end
            pending <= sorted_words.size();
        end
    end

endmodule

/* dv/stack_insertion_sorter_core_tb.sv */
// testbench top for the stack insertion sorter: stimulus, stall pattern and verdict
module stack_insertion_sorter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = sis_pkg::DEFAULT_DEPTH;
    localparam int VALUE_WIDTH = sis_pkg::DEFAULT_VALUE_WIDTH;
    localparam int W           = sis_pkg::FIELD_W;
    localparam int RANDOM_ITEMS = 190;   // runs start while values_sent < this + 22
    localparam int HOLD_AT_WORD = 40;    // result word at which the receiver stalls for long
    localparam int HOLD_CYCLES  = 90;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [W-1:0] s_tdata  = '0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [W-1:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    int errors;
    int pending;
    int checked;

    int values_sent = 0;
    int runs_sent   = 0;
    int overflow_runs = 0;

    always #5 aclk = ~aclk;

    stack_insertion_sorter_core #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    sorted_run_checker #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    // offer one input word after a random gap (none when quiet); valid stays high on return so
    // back-to-back words do not drop it for a step
    task automatic send_word(input logic [W-1:0] v, input logic l, input bit quiet);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        values_sent++;
        if (l) runs_sent++;
    endtask

    // sender pause: drop valid and hold until the checker has nothing outstanding;
    // the first edge lets the checker register the run just closed
    task automatic drain_all();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // pick a value for a run; the mode decides how the set is shaped
    function automatic logic [W-1:0] pick_value(int mode);
        case (mode)
            0: pick_value = W'($urandom);
            1: pick_value = W'($urandom_range(0, 7));               // many duplicates
            2: begin                                                  // field extremes
                case ($urandom_range(0, 5))
                    0: pick_value = 16'h0000;
                    1: pick_value = 16'hffff;
                    2: pick_value = 16'h0001;
                    3: pick_value = 16'hfffe;
                    4: pick_value = 16'h8000;
                    default: pick_value = 16'h7fff;
                endcase
            end
            default: pick_value = 16'hfff0 | W'($urandom_range(0, 15)); // crowded top
        endcase
    endfunction

    // receiver: random ready gaps per word with stretches of none, plus one long
    // stall before a chosen result word
    initial begin : receiver
        int delay;
        int words;
        bit busy_phase;
        words = 0;
        busy_phase = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (words % 24 == 0) busy_phase = $urandom_range(0, 1);
            delay = busy_phase ? 0 : $urandom_range(0, 7);
            if (words == HOLD_AT_WORD) delay = HOLD_CYCLES;
            if (delay > 0) begin
                m_tready <= 1'b0;
                repeat (delay) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            words++;
        end
    end

    // stimulus: directed runs first, then random runs of mixed length
    initial begin : stimulus
        int  set_len;
        int  value_mode;
        bit  quiet_set;
        logic [W-1:0] v;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-value run at the top extreme: one result, marked last
        send_word(16'hffff, 1'b1, 1'b0);

        // duplicates and both extremes in one run
        send_word(16'h0005, 1'b0, 1'b0);
        send_word(16'h0005, 1'b0, 1'b1);
        send_word(16'h0000, 1'b0, 1'b0);
        send_word(16'hffff, 1'b0, 1'b0);
        send_word(16'h0005, 1'b1, 1'b1);

        // descending run one longer than the store: the last value is dropped
        // and every result of the run carries the overflow flag
        for (int i = 0; i <= DEPTH; i++) begin
            send_word(W'(1000 - i * 37), (i == DEPTH), 1'b0);
        end
        overflow_runs++;

        // let every result of the directed part come out before going random
        drain_all();

        while (values_sent < RANDOM_ITEMS + 22) begin
            if ($urandom_range(0, 6) == 0) set_len = $urandom_range(DEPTH + 1, DEPTH + 6);
            else if ($urandom_range(0, 4) == 0) set_len = DEPTH;
            else set_len = $urandom_range(1, DEPTH - 1);
            if (set_len > DEPTH) overflow_runs++;
            value_mode = $urandom_range(0, 3);
            quiet_set  = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < set_len; i++) begin
                v = pick_value(value_mode);
                send_word(v, (i == set_len - 1), quiet_set);
            end
            // now and then the sender waits until every result is back
            if ($urandom_range(0, 9) == 0) drain_all();
        end

        drain_all();
        // stray words after the last expected one would still be flagged
        repeat (20) @(posedge aclk);

        $display("covered %0d runs (%0d overflowing), %0d values in, %0d sorted words checked",
                 runs_sent, overflow_runs, values_sent, checked);
        $display("with random gaps on both sides and one long receiver stall");
        if (errors == 0) begin
            $display("stack_insertion_sorter_core_tb: clean");
        end else begin
            $display("stack_insertion_sorter_core_tb: errors");
        end
        $finish;
    end

    // run limit far beyond the slowest correct run
    initial begin : watchdog
        #(1_000_000);
        $display("timeout waiting for the sorter");
        $display("stack_insertion_sorter_core_tb: errors");
        $finish;
    end

endmodule

/* stack_insertion_sorter_core.f */
rtl/sis_pkg.sv
rtl/sis_cell.sv
rtl/stack_insertion_sorter_core.sv
dv/sorted_run_checker.sv
dv/stack_insertion_sorter_core_tb.sv
